[src/mecanum_wheel_speed_resolver_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the mecanum wheel speed resolver
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_RESOLVER_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_RESOLVER_ASSERT_SVH

// same-cycle implication
`define MWSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MWSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/mwsr_pkg.sv]
// ----------------------------------------------------------------------------
// mwsr_pkg
// Types and constants shared by the mecanum wheel speed resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsr_pkg;

	localparam int DEG_NUM  = 573;  // 57.3 deg/rad, times ten
	localparam int VEL_W    = 20;
	localparam int CLP_W    = 17;   // clamped velocity, signed
	localparam int ARM_W    = 15;   // rotation arm, signed
	localparam int LIN_W    = 28;
	localparam int ROT_W    = 32;
	localparam int SUM_W    = 35;   // wheel sum, signed
	localparam int MAG_W    = 34;
	localparam int QUO_W    = 19;   // quotient never exceeds 16*wheel_limit
	localparam int DEN_W    = MAG_W;
	localparam int REM_W    = DEN_W + QUO_W;
	localparam int CFG_W    = 24;

	localparam logic [15:0] VX_LIMIT_RST    = 16'd50000;
	localparam logic [15:0] VY_LIMIT_RST    = 16'd50000;
	localparam logic [15:0] VW_LIMIT_RST    = 16'd50000;
	localparam logic [14:0] WHEEL_LIMIT_RST = 15'd8000;
	localparam logic [23:0] RPM_RATIO_RST   = 24'd110838;
	localparam logic [11:0] HALF_SPAN_RST   = 12'd300;

	typedef enum logic [2:0] {
		REG_VX_LIMIT    = 3'd0,
		REG_VY_LIMIT    = 3'd1,
		REG_VW_LIMIT    = 3'd2,
		REG_WHEEL_LIMIT = 3'd3,
		REG_RPM_RATIO   = 3'd4,
		REG_HALF_SPAN   = 3'd5,
		REG_X_OFFSET    = 3'd6,
		REG_Y_OFFSET    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_rot;
	} in_word_t;

	typedef struct packed {
		logic signed [19:0] wheel_front_right;
		logic signed [19:0] wheel_front_left;
		logic signed [19:0] wheel_back_left;
		logic signed [19:0] wheel_back_right;
		logic               was_scaled;
	} out_word_t;

endpackage

`default_nettype wire

[src/mwsr_div_pipe.sv]
// ----------------------------------------------------------------------------
// mwsr_div_pipe
// Pipelined restoring divider, one quotient bit per stage. Requires
// num < den * 2**QUO_W.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsr_div_pipe #(
	parameter int DEN_W = mwsr_pkg::DEN_W,
	parameter int QUO_W = mwsr_pkg::QUO_W
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [DEN_W+QUO_W-1:0] num,
	input  wire logic [DEN_W-1:0]       den,
	output logic      [QUO_W-1:0]       quo
);

	localparam int R_W = DEN_W + QUO_W;

	logic [R_W-1:0]   rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int B = QUO_W - 1 - k;
		logic [R_W-1:0]   rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [R_W-1:0]   shifted;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign shifted = R_W'(den_in) << B;
		assign ge      = rem_in >= shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rem_in - shifted : rem_in;
				den_s[k] <= den_in;
				quo_s[k] <= quo_in | (QUO_W'(ge) << B);
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

`default_nettype wire

[src/mecanum_wheel_speed_resolver.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_resolver
// Four-wheel mecanum inverse kinematics. Takes a chassis velocity word
// (vel_x, vel_y in mm/s, vel_rot in deg/s), clamps each component to its
// limit register, forms the four wheel speeds with their rotation arms,
// converts to 1/16 rpm through rpm_ratio and, when the fastest wheel exceeds
// wheel_limit, scales all four down together and flags was_scaled. Results
// round toward zero. Fully pipelined: one word in and one word out per
// cycle while the output is not stalled; 7 arithmetic stages, 19 divider
// stages of one quotient bit each, one output register. A stall on the
// output freezes the whole pipe. Registers are written through cfg_we /
// cfg_idx / cfg_data and must only change while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_speed_resolver (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire mwsr_pkg::in_word_t       in_data,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output mwsr_pkg::out_word_t           out_data,
	input  wire logic                     cfg_we,
	input  wire logic [2:0]               cfg_idx,
	input  wire logic [mwsr_pkg::CFG_W-1:0] cfg_data
);

	localparam int CLP_W = mwsr_pkg::CLP_W;
	localparam int ARM_W = mwsr_pkg::ARM_W;
	localparam int LIN_W = mwsr_pkg::LIN_W;
	localparam int ROT_W = mwsr_pkg::ROT_W;
	localparam int SUM_W = mwsr_pkg::SUM_W;
	localparam int MAG_W = mwsr_pkg::MAG_W;
	localparam int QUO_W = mwsr_pkg::QUO_W;
	localparam int REM_W = mwsr_pkg::REM_W;
	localparam int PRD_W = MAG_W + 24;    // |S| * rpm_ratio
	localparam int SPR_W = MAG_W + 15;    // |S| * wheel_limit
	localparam int THR_W = 25;            // wheel_limit * 573

	// wheel lanes: 0 front right, 1 front left, 2 back left, 3 back right

	// ---------------- configuration registers ----------------
	logic        [15:0] vx_lim_q, vy_lim_q, vw_lim_q;
	logic        [14:0] wheel_lim_q;
	logic        [23:0] ratio_q;
	logic        [11:0] half_span_q;
	logic signed [11:0] x_off_q, y_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_lim_q    <= mwsr_pkg::VX_LIMIT_RST;
			vy_lim_q    <= mwsr_pkg::VY_LIMIT_RST;
			vw_lim_q    <= mwsr_pkg::VW_LIMIT_RST;
			wheel_lim_q <= mwsr_pkg::WHEEL_LIMIT_RST;
			ratio_q     <= mwsr_pkg::RPM_RATIO_RST;
			half_span_q <= mwsr_pkg::HALF_SPAN_RST;
			x_off_q     <= '0;
			y_off_q     <= '0;
		end else if (cfg_we) begin
			case (mwsr_pkg::cfg_idx_t'(cfg_idx))
				mwsr_pkg::REG_VX_LIMIT:    vx_lim_q    <= cfg_data[15:0];
				mwsr_pkg::REG_VY_LIMIT:    vy_lim_q    <= cfg_data[15:0];
				mwsr_pkg::REG_VW_LIMIT:    vw_lim_q    <= cfg_data[15:0];
				mwsr_pkg::REG_WHEEL_LIMIT: wheel_lim_q <= cfg_data[14:0];
				mwsr_pkg::REG_RPM_RATIO:   ratio_q     <= cfg_data[23:0];
				mwsr_pkg::REG_HALF_SPAN:   half_span_q <= cfg_data[11:0];
				mwsr_pkg::REG_X_OFFSET:    x_off_q     <= cfg_data[11:0];
				mwsr_pkg::REG_Y_OFFSET:    y_off_q     <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// Every stage moves together; the pipe only halts when the output
	// register holds a word nobody takes.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	function automatic logic signed [CLP_W-1:0] clamp(
		input logic signed [19:0] v,
		input logic        [15:0] lim
	);
		logic signed [20:0] l;
		logic signed [20:0] x;
		l = signed'({5'd0, lim});
		x = 21'(v);
		if (x > l)
			return CLP_W'(l);
		else if (x < -l)
			return CLP_W'(-l);
		else
			return CLP_W'(x);
	endfunction

	// ---------------- stage 1: clamp, rotation arms ----------------
	logic                    v_s1;
	logic signed [CLP_W-1:0] vx_s1, vy_s1, vw_s1;
	logic signed [ARM_W-1:0] arm_s1 [4];
	logic signed [ARM_W-1:0] hs_ext, xo_ext, yo_ext;

	assign hs_ext = ARM_W'(signed'({1'b0, half_span_q}));
	assign xo_ext = ARM_W'(x_off_q);
	assign yo_ext = ARM_W'(y_off_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s1     <= clamp(in_data.vel_x, vx_lim_q);
			vy_s1     <= clamp(in_data.vel_y, vy_lim_q);
			vw_s1     <= clamp(in_data.vel_rot, vw_lim_q);
			arm_s1[0] <= hs_ext - xo_ext + yo_ext;
			arm_s1[1] <= hs_ext - xo_ext - yo_ext;
			arm_s1[2] <= hs_ext + xo_ext - yo_ext;
			arm_s1[3] <= hs_ext + xo_ext + yo_ext;
		end
	end

	// ---------------- stage 2: translation and rotation products ----------------
	logic                    v_s2;
	logic signed [LIN_W-1:0] lin_s2 [4];
	logic signed [ROT_W-1:0] rot_s2 [4];
	logic signed [CLP_W:0]   dsum   [4];

	always_comb begin
		dsum[0] = (CLP_W+1)'(vy_s1) - (CLP_W+1)'(vx_s1);
		dsum[1] = (CLP_W+1)'(vx_s1) + (CLP_W+1)'(vy_s1);
		dsum[2] = (CLP_W+1)'(vx_s1) - (CLP_W+1)'(vy_s1);
		dsum[3] = -(CLP_W+1)'(vx_s1) - (CLP_W+1)'(vy_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				lin_s2[i] <= LIN_W'(dsum[i]) * LIN_W'(mwsr_pkg::DEG_NUM);
				rot_s2[i] <= ROT_W'(vw_s1) * ROT_W'(arm_s1[i]);
			end
		end
	end

	// ---------------- stage 3: wheel sums S = lin + 10*rot ----------------
	logic                    v_s3;
	logic signed [SUM_W-1:0] sum_s3 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++)
				sum_s3[i] <= SUM_W'(lin_s2[i]) + (SUM_W'(rot_s2[i]) <<< 3)
					+ (SUM_W'(rot_s2[i]) <<< 1);
		end
	end

	// ---------------- stage 4: magnitudes ----------------
	logic             v_s4;
	logic [MAG_W-1:0] mag_s4 [4];
	logic [3:0]       neg_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				neg_s4[i] <= sum_s3[i][SUM_W-1];
				mag_s4[i] <= sum_s3[i][SUM_W-1] ? MAG_W'(-sum_s3[i]) : MAG_W'(sum_s3[i]);
			end
		end
	end

	// ---------------- stage 5: largest magnitude ----------------
	logic             v_s5;
	logic [MAG_W-1:0] mag_s5 [4];
	logic [MAG_W-1:0] smax_s5;
	logic [3:0]       neg_s5;
	logic [MAG_W-1:0] max_a, max_b;

	assign max_a = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
	assign max_b = (mag_s4[2] > mag_s4[3]) ? mag_s4[2] : mag_s4[3];

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			smax_s5 <= (max_a > max_b) ? max_a : max_b;
		end
	end

	// ---------------- stage 6: ratio and limit products ----------------
	logic             v_s6;
	logic [PRD_W-1:0] prod_s6  [4];
	logic [SPR_W-1:0] sprod_s6 [4];
	logic [PRD_W-1:0] mprod_s6;
	logic [THR_W-1:0] thr_s6;
	logic [MAG_W-1:0] smax_s6;
	logic [3:0]       neg_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				prod_s6[i]  <= PRD_W'(mag_s5[i]) * PRD_W'(ratio_q);
				sprod_s6[i] <= SPR_W'(mag_s5[i]) * SPR_W'(wheel_lim_q);
			end
			mprod_s6 <= PRD_W'(smax_s5) * PRD_W'(ratio_q);
			thr_s6   <= THR_W'(wheel_lim_q) * THR_W'(mwsr_pkg::DEG_NUM);
			smax_s6  <= smax_s5;
			neg_s6   <= neg_s5;
		end
	end

	// ---------------- stage 7: pick dividend and divisor ----------------
	// Scaled:   q = 16*wheel_limit*|S| / max|S|
	// Unscaled: q = (|S|*ratio >> 20) / 573
	// Either way q fits in QUO_W bits.
	logic             v_s7;
	logic [REM_W-1:0] num_s7 [4];
	logic [MAG_W-1:0] den_s7;
	logic [3:0]       neg_s7;
	logic             scl_s7;
	logic             scl_now;

	assign scl_now = mprod_s6 > PRD_W'({thr_s6, 24'd0});

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++)
				num_s7[i] <= scl_now ? REM_W'({sprod_s6[i], 4'd0})
					: REM_W'(prod_s6[i] >> 20);
			den_s7 <= scl_now ? smax_s6 : MAG_W'(mwsr_pkg::DEG_NUM);
			neg_s7 <= neg_s6;
			scl_s7 <= scl_now;
		end
	end

	// ---------------- divider lanes ----------------
	logic [QUO_W-1:0] quo [4];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		mwsr_div_pipe #(
			.DEN_W (MAG_W),
			.QUO_W (QUO_W)
		) u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s7[l]),
			.den (den_s7),
			.quo (quo[l])
		);
	end

	// sign and flag ride alongside the divider
	logic [QUO_W-1:0] dv_s;
	logic [3:0]       dneg_s [QUO_W];
	logic             dscl_s [QUO_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			dneg_s[0] <= neg_s7;
			dscl_s[0] <= scl_s7;
			for (int k = 1; k < QUO_W; k++) begin
				dneg_s[k] <= dneg_s[k-1];
				dscl_s[k] <= dscl_s[k-1];
			end
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			dv_s      <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			dv_s      <= {dv_s[QUO_W-2:0], v_s7};
			out_valid <= dv_s[QUO_W-1];
		end
	end

	// ---------------- output register: restore sign ----------------
	function automatic logic signed [19:0] signed_q(
		input logic             neg,
		input logic [QUO_W-1:0] q
	);
		return neg ? -20'(q) : 20'(q);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.wheel_front_right <= signed_q(dneg_s[QUO_W-1][0], quo[0]);
			out_data.wheel_front_left  <= signed_q(dneg_s[QUO_W-1][1], quo[1]);
			out_data.wheel_back_left   <= signed_q(dneg_s[QUO_W-1][2], quo[2]);
			out_data.wheel_back_right  <= signed_q(dneg_s[QUO_W-1][3], quo[3]);
			out_data.was_scaled        <= dscl_s[QUO_W-1];
		end
	end

endmodule

`default_nettype wire

[src/mwsr_checker.sv]
// ----------------------------------------------------------------------------
// mwsr_checker
// Port-level checks for the mecanum wheel speed resolver, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mecanum_wheel_speed_resolver_assert.svh"

module mwsr_port_checks (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire mwsr_pkg::out_word_t out_data
);

	// a stalled output word holds
	`MWSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")

	// input side stalls only when the output register is blocked
	`MWSR_ASSERT_NOW(a_ready_flow, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow output flow")

	// magnitudes are bounded by 16*32767, so the most negative code never shows
	`MWSR_ASSERT_NOW(a_no_min_code, out_valid, out_data.wheel_front_right != 20'h80000 && out_data.wheel_front_left != 20'h80000 && out_data.wheel_back_left != 20'h80000 && out_data.wheel_back_right != 20'h80000, "wheel speed out of range")

endmodule

bind mecanum_wheel_speed_resolver mwsr_port_checks u_mwsr_checker (.*);

`default_nettype wire
